// ===== sv/ipa_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ipa_pkg
// Shared types and constants for the IPv4 address pool allocator: pool
// geometry, bitmap word layout, host numbering, divider constants, register
// indexes, request modes, status codes and the request and response words.
// ============================================================================
package ipa_pkg;

    // Pool geometry.
    localparam int POOL_DEPTH = 1024;
    localparam int OWNER_BITS = 16;

    // The in-use bitmap is kept in 32-bit words.
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int NUM_WORDS = (POOL_DEPTH + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FIDX_W    = WADDR_W + BIT_W;
    localparam int IDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(POOL_DEPTH + 1);

    // Host numbering inside one /24: .0 and .255 are skipped.
    localparam int HOSTS_PER_NET = 'hfe;
    localparam int HOST_LAST     = 'hff;
    localparam int SKIP_STEP     = 2;

    // Index to address: index / 254 through a fixed-point reciprocal.
    localparam int DIV_IN_W    = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / HOSTS_PER_NET;
    localparam int RECIP_W     = 17;
    localparam int PROD_W      = DIV_IN_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MIN_IP        = 2'd0,
        REG_MAX_IP        = 2'd1,
        REG_DNS_PRIMARY   = 2'd2,
        REG_DNS_SECONDARY = 2'd3
    } cfg_reg_t;

    // Request modes.
    localparam logic MODE_APPLY   = 1'b0;
    localparam logic MODE_RECOVER = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_OWNED = 2'd3
    } status_t;

    // Request word.
    typedef struct packed {
        logic        mode;
        logic [31:0] requested_ip;
        logic [15:0] owner_tag;
    } req_t;

    // Response word.
    typedef struct packed {
        status_t     status;
        logic [31:0] granted_ip;
        logic [31:0] dns_first;
        logic [31:0] dns_second;
    } rsp_t;

endpackage

// ===== sv/ip_address_pool_allocator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ip_address_pool_allocator
// IPv4 address pool with first-free allocation, owner tags and release.
// The in-use bitmap and the owner tags live in synchronous memories that
// are read, modified and written back by a small sequencer.
// ============================================================================
//
//  Channel  Ports                         Word
//  -------  ----------------------------  ------------------------------
//  cfg      cfg_valid/cfg_ready           cfg_index (2b), cfg_wdata (32b)
//  request  s_valid/s_ready/s_data        ipa_pkg::req_t
//  result   m_valid/m_ready/m_data        ipa_pkg::rsp_t
//
//  One request is handled at a time. A release or a request for a given
//  address goes through the range states, dispatch, a read-modify-write
//  and the output state, and skips the read-modify-write when it is rejected
//  before the memories are touched; an apply for any free address scans up
//  to NUM_WORDS bitmap words, one per cycle, a rate bounded by the bitmap
//  memory's single read port. A new request is taken while a result waits.
//  Reset is synchronous; a write to min_ip or max_ip clears every bitmap
//  row at once through per-row valid flags, so no clearing pass exists.
//  cfg_ready is always high.
//
module ip_address_pool_allocator (
    input  logic           aclk,
    input  logic           aresetn,

    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wdata,

    input  logic           s_valid,
    output logic           s_ready,
    input  ipa_pkg::req_t  s_data,

    output logic           m_valid,
    input  logic           m_ready,
    output ipa_pkg::rsp_t  m_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_CNT,
        S_CLAMP,
        S_DISPATCH,
        S_SCAN,
        S_RMW,
        S_DIV1,
        S_DIV2,
        S_DIV3,
        S_ADDR,
        S_OUT
    } state_t;

    // Configuration, kept in normalized form.
    logic [31:0] first_reg, first_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] dns_pri_reg, dns_pri_next;
    logic [31:0] dns_sec_reg, dns_sec_next;

    // Sequencer state.
    state_t               state_reg, state_next;
    ipa_pkg::req_t        req_reg, req_next;
    logic [32:0]          span_reg, span_next;
    logic [24:0]          netd_reg, netd_next;
    logic                 order_ok_reg, order_ok_next;
    logic [31:0]          ipd_reg, ipd_next;
    logic [31:0]          ipnet_reg, ipnet_next;
    logic signed [34:0]   n_reg, n_next;
    logic [ipa_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [31:0]          idx_reg, idx_next;
    logic [ipa_pkg::WADDR_W-1:0] exam_reg, exam_next;
    logic [ipa_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [ipa_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [7:0]           rem8_reg, rem8_next;
    ipa_pkg::status_t     status_reg, status_next;
    logic [31:0]          granted_reg, granted_next;
    logic                 m_valid_reg, m_valid_next;
    ipa_pkg::rsp_t        m_data_reg, m_data_next;
    logic [ipa_pkg::NUM_WORDS-1:0] row_valid_reg, row_valid_next;

    // Memories and their ports.
    logic [ipa_pkg::WORD_W-1:0]     used_mem [ipa_pkg::NUM_WORDS];
    logic [ipa_pkg::OWNER_BITS-1:0] own_mem  [ipa_pkg::POOL_DEPTH];

    logic                           used_we;
    logic [ipa_pkg::WADDR_W-1:0]    used_waddr;
    logic [ipa_pkg::WORD_W-1:0]     used_wdata;
    logic [ipa_pkg::WADDR_W-1:0]    used_raddr;
    logic [ipa_pkg::WORD_W-1:0]     used_rdata_reg;
    logic                           row_hit_reg;
    logic                           own_we;
    logic [ipa_pkg::IDX_W-1:0]      own_waddr;
    logic [ipa_pkg::OWNER_BITS-1:0] own_wdata;
    logic [ipa_pkg::IDX_W-1:0]      own_raddr;
    logic [ipa_pkg::OWNER_BITS-1:0] own_rdata_reg;

    // Helper signals.
    logic [31:0]                    cfg_first;
    logic [31:0]                    cfg_last;
    logic [ipa_pkg::WORD_W-1:0]     word_eff;
    logic [ipa_pkg::WORD_W-1:0]     free_vec;
    logic                           free_any;
    logic [ipa_pkg::BIT_W-1:0]      free_pos;
    logic [ipa_pkg::FIDX_W-1:0]     found_idx;
    logic [ipa_pkg::BIT_W-1:0]      bit_sel;
    logic [ipa_pkg::WORD_W-1:0]     bit_mask;
    logic [ipa_pkg::OWNER_BITS-1:0] tag_trim;
    logic [ipa_pkg::DIV_IN_W-1:0]   idx16;
    logic [ipa_pkg::DIV_IN_W-1:0]   rem_full;
    logic                           idx_out_range;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Normalize the incoming minimum and maximum addresses.
    always_comb begin
        if (cfg_wdata[7:0] == 8'h00) begin
            cfg_first = cfg_wdata + 32'd1;
            cfg_last  = cfg_wdata - 32'(ipa_pkg::SKIP_STEP);
        end else if (cfg_wdata[7:0] == 8'(ipa_pkg::HOST_LAST)) begin
            cfg_first = cfg_wdata + 32'(ipa_pkg::SKIP_STEP);
            cfg_last  = cfg_wdata - 32'd1;
        end else begin
            cfg_first = cfg_wdata;
            cfg_last  = cfg_wdata;
        end
    end

    // Bitmap word as seen through its row valid flag, and the free search.
    assign word_eff  = row_hit_reg ? used_rdata_reg : '0;
    assign tag_trim  = ipa_pkg::OWNER_BITS'(req_reg.owner_tag);
    assign bit_sel   = idx_reg[ipa_pkg::BIT_W-1:0];
    assign bit_mask  = ipa_pkg::WORD_W'(1) << bit_sel;
    assign found_idx = {exam_reg, free_pos};
    assign idx16     = ipa_pkg::DIV_IN_W'(idx_reg[ipa_pkg::FIDX_W-1:0]);
    assign rem_full  = idx16 - ipa_pkg::DIV_IN_W'(quo_reg)
                       * ipa_pkg::DIV_IN_W'(ipa_pkg::HOSTS_PER_NET);
    assign idx_out_range = (idx_reg >= 32'(count_reg));

    always_comb begin
        for (int b = 0; b < ipa_pkg::WORD_W; b++) begin
            free_vec[b] = !word_eff[b]
                && (32'({exam_reg, ipa_pkg::BIT_W'(b)}) < 32'(count_reg));
        end
        free_any = |free_vec;
        free_pos = '0;
        for (int b = ipa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                free_pos = ipa_pkg::BIT_W'(b);
            end
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        first_next     = first_reg;
        last_next      = last_reg;
        dns_pri_next   = dns_pri_reg;
        dns_sec_next   = dns_sec_reg;
        state_next     = state_reg;
        req_next       = req_reg;
        span_next      = span_reg;
        netd_next      = netd_reg;
        order_ok_next  = order_ok_reg;
        ipd_next       = ipd_reg;
        ipnet_next     = ipnet_reg;
        n_next         = n_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        exam_next      = exam_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        rem8_next      = rem8_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        row_valid_next = row_valid_reg;

        used_we    = 1'b0;
        used_waddr = idx_reg[ipa_pkg::FIDX_W-1:ipa_pkg::BIT_W];
        used_wdata = word_eff | bit_mask;
        used_raddr = idx_reg[ipa_pkg::FIDX_W-1:ipa_pkg::BIT_W];
        own_we     = 1'b0;
        own_waddr  = idx_reg[ipa_pkg::IDX_W-1:0];
        own_wdata  = tag_trim;
        own_raddr  = idx_reg[ipa_pkg::IDX_W-1:0];

        // Configuration writes; a new pool range frees every entry.
        if (cfg_valid) begin
            unique case (cfg_index)
                ipa_pkg::REG_MIN_IP: begin
                    first_next     = cfg_first;
                    row_valid_next = '0;
                end
                ipa_pkg::REG_MAX_IP: begin
                    last_next      = cfg_last;
                    row_valid_next = '0;
                end
                ipa_pkg::REG_DNS_PRIMARY: begin
                    dns_pri_next = cfg_wdata;
                end
                ipa_pkg::REG_DNS_SECONDARY: begin
                    dns_sec_next = cfg_wdata;
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_CALC;
                end
            end

            // Range span and the request's raw offset from the first address.
            S_CALC: begin
                span_next     = {1'b0, last_reg} - {1'b0, first_reg};
                order_ok_next = (last_reg >= first_reg);
                netd_next     = {1'b0, last_reg[31:8]} - {1'b0, first_reg[31:8]};
                ipd_next      = req_reg.requested_ip - first_reg;
                ipnet_next    = {8'h00, req_reg.requested_ip[31:8]}
                                - {8'h00, first_reg[31:8]};
                state_next    = S_CNT;
            end

            // Entry count before clamping and the request's index.
            S_CNT: begin
                n_next     = signed'({2'b00, span_reg}) + 35'sd1
                             - signed'({9'd0, netd_reg, 1'b0});
                idx_next   = ipd_reg - {ipnet_reg[30:0], 1'b0};
                state_next = S_CLAMP;
            end

            S_CLAMP: begin
                if (!order_ok_reg || n_reg <= 35'sd0) begin
                    count_next = '0;
                end else if (n_reg > 35'(ipa_pkg::POOL_DEPTH)) begin
                    count_next = ipa_pkg::CNT_W'(ipa_pkg::POOL_DEPTH);
                end else begin
                    count_next = ipa_pkg::CNT_W'(n_reg);
                end
                state_next = S_DISPATCH;
            end

            // Pick the path; reads for it are issued here.
            S_DISPATCH: begin
                granted_next = req_reg.requested_ip;
                if (req_reg.mode == ipa_pkg::MODE_APPLY
                    && req_reg.requested_ip == 32'd0) begin
                    used_raddr = '0;
                    exam_next  = '0;
                    state_next = S_SCAN;
                end else if (req_reg.mode == ipa_pkg::MODE_RECOVER
                    && req_reg.requested_ip == 32'd0) begin
                    status_next = ipa_pkg::ST_INVALID;
                    state_next  = S_OUT;
                end else if (idx_out_range) begin
                    status_next = ipa_pkg::ST_FULL;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_RMW;
                end
            end

            // One bitmap word examined per cycle while the next one is read.
            S_SCAN: begin
                used_raddr = (32'(exam_reg) == 32'(ipa_pkg::NUM_WORDS - 1))
                             ? exam_reg : exam_reg + ipa_pkg::WADDR_W'(1);
                exam_next  = used_raddr;
                if (free_any) begin
                    used_we     = 1'b1;
                    used_waddr  = exam_reg;
                    used_wdata  = word_eff | (ipa_pkg::WORD_W'(1) << free_pos);
                    own_we      = 1'b1;
                    own_waddr   = ipa_pkg::IDX_W'(found_idx);
                    row_valid_next[exam_reg] = 1'b1;
                    idx_next    = 32'(found_idx);
                    status_next = ipa_pkg::ST_OK;
                    state_next  = S_DIV1;
                end else if (32'(exam_reg) == 32'(ipa_pkg::NUM_WORDS - 1)) begin
                    status_next = ipa_pkg::ST_FULL;
                    state_next  = S_OUT;
                end
            end

            // Read-modify-write of one entry for a given address.
            S_RMW: begin
                used_waddr = idx_reg[ipa_pkg::FIDX_W-1:ipa_pkg::BIT_W];
                if (req_reg.mode == ipa_pkg::MODE_APPLY) begin
                    used_we     = 1'b1;
                    used_wdata  = word_eff | bit_mask;
                    own_we      = 1'b1;
                    row_valid_next[used_waddr] = 1'b1;
                    status_next = ipa_pkg::ST_OK;
                end else if (word_eff[bit_sel] && own_rdata_reg == tag_trim) begin
                    used_we     = 1'b1;
                    used_wdata  = word_eff & ~bit_mask;
                    row_valid_next[used_waddr] = 1'b1;
                    status_next = ipa_pkg::ST_OK;
                end else begin
                    status_next = ipa_pkg::ST_NOT_OWNED;
                end
                state_next = S_OUT;
            end

            // Quotient estimate by reciprocal multiplication.
            S_DIV1: begin
                prod_next  = ipa_pkg::PROD_W'(idx16)
                             * ipa_pkg::PROD_W'(ipa_pkg::RECIP);
                state_next = S_DIV2;
            end

            S_DIV2: begin
                quo_next   = prod_reg[ipa_pkg::PROD_W-1:ipa_pkg::RECIP_SHIFT];
                state_next = S_DIV3;
            end

            // The estimate is at most one low: correct it.
            S_DIV3: begin
                if (rem_full >= ipa_pkg::DIV_IN_W'(ipa_pkg::HOSTS_PER_NET)) begin
                    quo_next  = quo_reg + ipa_pkg::QUO_W'(1);
                    rem8_next = 8'(rem_full - ipa_pkg::DIV_IN_W'(ipa_pkg::HOSTS_PER_NET));
                end else begin
                    rem8_next = rem_full[7:0];
                end
                state_next = S_ADDR;
            end

            // Address of the found index, stepping over .255 and .0.
            S_ADDR: begin
                granted_next = first_reg + (32'(quo_reg) << 8) + 32'(rem8_reg);
                if ((9'(rem8_reg) + 9'(first_reg[7:0])) >= 9'(ipa_pkg::HOST_LAST)) begin
                    granted_next = first_reg + (32'(quo_reg) << 8) + 32'(rem8_reg)
                                   + 32'(ipa_pkg::SKIP_STEP);
                end
                state_next = S_OUT;
            end

            // Hand the result to the output register once it is free.
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_data_next.status = status_reg;
                    if (req_reg.mode == ipa_pkg::MODE_APPLY
                        && status_reg == ipa_pkg::ST_OK) begin
                        m_data_next.granted_ip = granted_reg;
                        m_data_next.dns_first  = dns_pri_reg;
                        m_data_next.dns_second = dns_sec_reg;
                    end else begin
                        m_data_next.granted_ip = '0;
                        m_data_next.dns_first  = '0;
                        m_data_next.dns_second = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
            first_reg     <= 32'd1;
            last_reg      <= 32'hffff_fffe;
            dns_pri_reg   <= '0;
            dns_sec_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            row_valid_reg <= row_valid_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            dns_pri_reg   <= dns_pri_next;
            dns_sec_reg   <= dns_sec_next;
        end
        req_reg      <= req_next;
        span_reg     <= span_next;
        netd_reg     <= netd_next;
        order_ok_reg <= order_ok_next;
        ipd_reg      <= ipd_next;
        ipnet_reg    <= ipnet_next;
        n_reg        <= n_next;
        count_reg    <= count_next;
        idx_reg      <= idx_next;
        exam_reg     <= exam_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem8_reg     <= rem8_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        m_data_reg   <= m_data_next;
    end

    // In-use bitmap memory, one word per row, with the row flag read along.
    always_ff @(posedge aclk) begin
        if (used_we) begin
            used_mem[used_waddr] <= used_wdata;
        end
        used_rdata_reg <= used_mem[used_raddr];
        row_hit_reg    <= row_valid_reg[used_raddr];
    end

    // Owner tag memory.
    always_ff @(posedge aclk) begin
        if (own_we) begin
            own_mem[own_waddr] <= own_wdata;
        end
        own_rdata_reg <= own_mem[own_raddr];
    end

endmodule
